// ----- sv/scog_pkg.sv -----
// Shared types and constants for the sigma-clip outlier gate.
package scog_pkg;

   // Message classes carried on the request tuser field.
   localparam logic [1:0] OP_SAMPLE  = 2'd0;
   localparam logic [1:0] OP_STATUS  = 2'd1;
   localparam logic [1:0] OP_UNKNOWN = 2'd2;

   localparam int DIST_BITS     = 16;   // distance field width on the ports
   localparam int RSP_DATA_BITS = 24;   // accepted + altitude + link_ok, padded to bytes

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_SQ_OLD,
      ST_SQ_NEW,
      ST_NX,
      ST_DEV,
      ST_NSQ,
      ST_SUMSQ,
      ST_DECIDE,
      ST_FINISH
   } state_type;

endpackage

// ----- sv/scog_serial_mult.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module scog_serial_mult #(
   parameter int PW = 46,
   parameter int BW = 23
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [PW-1:0] a_in,
   input  logic [BW-1:0] b_in,
   output logic          done,
   output logic [PW-1:0] product
);

   logic [BW-1:0] b_ff;
   logic [PW-1:0] a_ff;
   logic [PW-1:0] acc_ff;

   // multiplier bits remaining; zero means finished
   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff <= '0;
      end else if (start) begin
         b_ff <= b_in;
      end else if (b_ff != '0) begin
         b_ff <= b_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a_in;
         acc_ff <= '0;
      end else if (b_ff != '0) begin
         if (b_ff[0]) begin
            acc_ff <= acc_ff + a_ff;
         end
         a_ff <= a_ff << 1;
      end
   end

   assign done    = (b_ff == '0);
   assign product = acc_ff;

endmodule

// ----- sv/sigma_clip_outlier_gate_unit.sv -----
// Top level of the sigma-clip outlier gate for classified rangefinder messages.
//
//  channel  dir  ports                          transaction
//  -------  ---  -----------------------------  --------------------------------------
//  req      in   req_tvalid/tready/tdata/tuser  one classified message
//  rsp      out  rsp_tvalid/tready/tdata/tuser  one result per message, in order
//
// Flow: a status or unknown message goes from idle straight to the finish step,
//   which loads its result and returns to idle, where the input is ready again.
//   A sample runs through one shared bit-serial multiplier, one multiplier
//   bit per cycle. While fewer than WINDOW samples are held after the append,
//   only the sample square is formed; with WINDOW or more held, five products
//   are formed, and six when the ring was full, the oldest sample's square first.
// Reset: synchronous, active high; window empty, sums zero, altitude zero,
//   link not ok. Window entries are not cleared, only counted.
// Stalls: the result sits in an output register; a new message is taken while
//   it waits, and the next result waits in the finish step until it drains.
module sigma_clip_outlier_gate_unit #(
   parameter int WINDOW      = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] distance_cm
   input  logic [1:0]  req_tuser,   // [1:0] operation
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] accepted, [16:1] altitude_cm, [17] link_ok, pad
   output logic        rsp_tuser    // [0] message_ok
);

   // ---------------------------------------------------------------------
   // Widths
   // ---------------------------------------------------------------------
   localparam int DEPTH = WINDOW + 1;           // ring keeps one extra sample
   localparam int PTRW  = $clog2(DEPTH);
   localparam int NB    = $clog2(WINDOW + 2);   // count holds 0..WINDOW+1
   localparam int SW    = SAMPLE_BITS;
   localparam int SUMW  = SW + NB;              // sum of up to DEPTH samples
   localparam int SQW   = 2 * SW + NB;          // sum of squares
   localparam int PW    = 2 * SUMW;             // any product in the gate test
   localparam int DW    = scog_pkg::DIST_BITS;
   localparam int XW    = (SW > DW) ? SW : DW;

   localparam logic [NB-1:0] CNT_FULL = NB'(WINDOW + 1);
   localparam logic [NB-1:0] CNT_WIN  = NB'(WINDOW);
   localparam logic [NB:0]   SLOT_MOD = (NB + 1)'(DEPTH);
   localparam logic [PTRW-1:0] PTR_LAST = PTRW'(DEPTH - 1);

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   scog_pkg::state_type state_ff, state_in;

   logic [SW-1:0]   window_ff [DEPTH];   // ring of samples, no reset
   logic [PTRW-1:0] oldest_ff;
   logic [NB-1:0]   count_ff;
   logic [SUMW-1:0] sum_ff;
   logic [SQW-1:0]  sumsq_ff;
   logic [SW-1:0]   held_ff;
   logic            link_ff;

   // per-transaction working registers
   logic [1:0]      op_ff;
   logic [SW-1:0]   x_ff;
   logic [SW-1:0]   old_ff;
   logic [SUMW-1:0] dev_ff;
   logic [PW-1:0]   lhs_ff;
   logic [PW-1:0]   nsq_ff;
   logic [PW-1:0]   var_ff;
   logic            acc_ff;
   logic            started_ff;

   // output register
   logic            rsp_tvalid_ff;
   logic [23:0]     rsp_tdata_ff;
   logic            rsp_tuser_ff;

   // ---------------------------------------------------------------------
   // Shared serial multiplier
   // ---------------------------------------------------------------------
   logic            mul_start;
   logic [PW-1:0]   mul_a;
   logic [SUMW-1:0] mul_b;
   logic            mul_done;
   logic [PW-1:0]   mul_prod;

   scog_serial_mult #(
      .PW (PW),
      .BW (SUMW)
   ) u_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a_in    (mul_a),
      .b_in    (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   // ---------------------------------------------------------------------
   // Helpers
   // ---------------------------------------------------------------------
   logic            req_fire;
   logic            rsp_load;
   logic            mul_state;
   logic            step_done;
   logic            link_in;
   logic [XW-1:0]   dist_ext;
   logic [XW-1:0]   held_ext;
   logic [NB-1:0]   count_inc;
   logic [NB:0]     slot_sum;
   logic [PTRW-1:0] slot;
   logic [SUMW-1:0] nx;
   logic [PW+1:0]   var_x4;

   assign req_fire  = req_tvalid && req_tready;
   assign dist_ext  = XW'(req_tdata[DW-1:0]);
   assign held_ext  = XW'(held_ff);
   assign count_inc = count_ff + 1'b1;
   assign slot_sum  = (NB + 1)'(oldest_ff) + (NB + 1)'(count_ff);
   assign slot      = (slot_sum >= SLOT_MOD) ? PTRW'(slot_sum - SLOT_MOD) : PTRW'(slot_sum);
   assign nx        = mul_prod[SUMW-1:0];
   assign var_x4    = {var_ff, 2'b00};

   always_comb begin
      case (state_ff)
         scog_pkg::ST_SQ_OLD,
         scog_pkg::ST_SQ_NEW,
         scog_pkg::ST_NX,
         scog_pkg::ST_DEV,
         scog_pkg::ST_NSQ,
         scog_pkg::ST_SUMSQ: mul_state = 1'b1;
         default:            mul_state = 1'b0;
      endcase
   end

   assign step_done = mul_state && started_ff && mul_done;

   // link status after the current message
   always_comb begin
      case (op_ff)
         scog_pkg::OP_SAMPLE: link_in = link_ff;
         scog_pkg::OP_STATUS: link_in = 1'b1;
         default:             link_in = 1'b0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scog_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser != scog_pkg::OP_SAMPLE) begin
                  state_in = scog_pkg::ST_FINISH;
               end else if (count_ff == CNT_FULL) begin
                  state_in = scog_pkg::ST_READ;
               end else begin
                  state_in = scog_pkg::ST_SQ_NEW;
               end
            end
         end
         scog_pkg::ST_READ:   state_in = scog_pkg::ST_SQ_OLD;
         scog_pkg::ST_SQ_OLD: if (step_done) state_in = scog_pkg::ST_SQ_NEW;
         scog_pkg::ST_SQ_NEW: begin
            if (step_done) begin
               state_in = (count_inc < CNT_WIN) ? scog_pkg::ST_FINISH : scog_pkg::ST_NX;
            end
         end
         scog_pkg::ST_NX:     if (step_done) state_in = scog_pkg::ST_DEV;
         scog_pkg::ST_DEV:    if (step_done) state_in = scog_pkg::ST_NSQ;
         scog_pkg::ST_NSQ:    if (step_done) state_in = scog_pkg::ST_SUMSQ;
         scog_pkg::ST_SUMSQ:  if (step_done) state_in = scog_pkg::ST_DECIDE;
         scog_pkg::ST_DECIDE: state_in = scog_pkg::ST_FINISH;
         scog_pkg::ST_FINISH: if (rsp_load) state_in = scog_pkg::ST_IDLE;
         default:             state_in = scog_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Control outputs and multiplier operands
   // ---------------------------------------------------------------------
   always_comb begin
      req_tready = (state_ff == scog_pkg::ST_IDLE);
      rsp_load   = (state_ff == scog_pkg::ST_FINISH) && (!rsp_tvalid_ff || rsp_tready);
      mul_start  = mul_state && !started_ff;
      case (state_ff)
         scog_pkg::ST_SQ_OLD: begin
            mul_a = PW'(old_ff);
            mul_b = SUMW'(old_ff);
         end
         scog_pkg::ST_SQ_NEW: begin
            mul_a = PW'(x_ff);
            mul_b = SUMW'(x_ff);
         end
         scog_pkg::ST_NX: begin
            mul_a = PW'(x_ff);
            mul_b = SUMW'(count_ff);
         end
         scog_pkg::ST_DEV: begin
            mul_a = PW'(dev_ff);
            mul_b = dev_ff;
         end
         scog_pkg::ST_NSQ: begin
            mul_a = PW'(sumsq_ff);
            mul_b = SUMW'(count_ff);
         end
         scog_pkg::ST_SUMSQ: begin
            mul_a = PW'(sum_ff);
            mul_b = sum_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Control registers and window bookkeeping
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= scog_pkg::ST_IDLE;
         started_ff    <= 1'b0;
         oldest_ff     <= '0;
         count_ff      <= '0;
         sum_ff        <= '0;
         sumsq_ff      <= '0;
         held_ff       <= '0;
         link_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (mul_start) begin
            started_ff <= 1'b1;
         end else if (step_done) begin
            started_ff <= 1'b0;
         end

         // drop the oldest sample
         if (state_ff == scog_pkg::ST_SQ_OLD && step_done) begin
            sum_ff    <= sum_ff - SUMW'(old_ff);
            sumsq_ff  <= sumsq_ff - mul_prod[SQW-1:0];
            oldest_ff <= (oldest_ff == PTR_LAST) ? '0 : oldest_ff + 1'b1;
            count_ff  <= count_ff - 1'b1;
         end

         // append the new sample; early samples pass without a test
         if (state_ff == scog_pkg::ST_SQ_NEW && step_done) begin
            sum_ff   <= sum_ff + SUMW'(x_ff);
            sumsq_ff <= sumsq_ff + mul_prod[SQW-1:0];
            count_ff <= count_inc;
            if (count_inc < CNT_WIN) begin
               held_ff <= x_ff;
            end
         end

         // two-sigma test: (n*x - sum)^2 <= 4*(n*sumsq - sum^2)
         if (state_ff == scog_pkg::ST_DECIDE && (PW + 2)'(lhs_ff) <= var_x4) begin
            held_ff <= x_ff;
         end

         if (rsp_load) begin
            link_ff <= link_in;
         end

         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Window memory: one write, one registered read
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (state_ff == scog_pkg::ST_SQ_NEW && step_done) begin
         window_ff[slot] <= x_ff;
      end
      old_ff <= window_ff[oldest_ff];
   end

   // ---------------------------------------------------------------------
   // Working registers (no reset)
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_tuser;
         x_ff   <= dist_ext[SW-1:0];
         acc_ff <= 1'b0;
      end

      if (state_ff == scog_pkg::ST_SQ_NEW && step_done && count_inc < CNT_WIN) begin
         acc_ff <= 1'b1;
      end
      if (state_ff == scog_pkg::ST_DECIDE && (PW + 2)'(lhs_ff) <= var_x4) begin
         acc_ff <= 1'b1;
      end

      if (state_ff == scog_pkg::ST_NX && step_done) begin
         dev_ff <= (nx >= sum_ff) ? nx - sum_ff : sum_ff - nx;
      end
      if (state_ff == scog_pkg::ST_DEV && step_done) begin
         lhs_ff <= mul_prod;
      end
      if (state_ff == scog_pkg::ST_NSQ && step_done) begin
         nsq_ff <= mul_prod;
      end
      if (state_ff == scog_pkg::ST_SUMSQ && step_done) begin
         var_ff <= (nsq_ff >= mul_prod) ? nsq_ff - mul_prod : '0;
      end
   end

   // Result register; link status follows the message class at load time.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tuser_ff <= (op_ff == scog_pkg::OP_SAMPLE) ||
                         (op_ff == scog_pkg::OP_STATUS);
         rsp_tdata_ff <= {6'd0, link_in, held_ext[15:0], acc_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff[scog_pkg::RSP_DATA_BITS-1:0];
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ----- test/sigma_clip_outlier_gate_unit_test.sv -----
// Self-checking testbench for the sigma-clip outlier gate: directed and random stream traffic, in-order result checks.
module sigma_clip_outlier_gate_unit_test;

   localparam logic [1:0] OP_RESERVED = 2'd3;   // decoded as unrecognized
   localparam int WIN          = 16;             // gate window, matches the block default
   localparam int RING_DEPTH   = WIN + 1;
   localparam int RANDOM_ITEMS = 1230;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 150;            // beyond the longest sample computation
   localparam int HOLD_CYCLES  = 400;            // long output stall in the last phase

   typedef struct {
      logic [1:0]                     op;
      logic [scog_pkg::DIST_BITS-1:0] distance;
   } range_msg_type;

   typedef struct {
      logic                           msg_ok;
      logic                           accepted;
      logic [scog_pkg::DIST_BITS-1:0] altitude;
      logic                           link_ok;
   } gate_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;    // [15:0] distance_cm
   logic [1:0]  req_tuser  = '0;    // [1:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;          // [0] accepted, [16:1] altitude_cm, [17] link_ok, pad
   logic        rsp_tuser;          // [0] message_ok

   sigma_clip_outlier_gate_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Gate state as the block should hold it.
   logic [scog_pkg::DIST_BITS-1:0] ring [RING_DEPTH];
   int                             ring_head   = 0;
   int                             ring_count  = 0;
   logic [20:0]                    win_sum     = '0;
   logic [36:0]                    win_sumsq   = '0;
   logic [scog_pkg::DIST_BITS-1:0] held_alt    = '0;
   logic                           link_flag   = 1'b0;

   range_msg_type   msg_q [$];          // messages waiting to be offered
   gate_result_type result_q [$];       // results owed by the block, oldest first
   range_msg_type   offered;
   int              planned_items = 0;
   int              sent_count    = 0;  // accepted transactions, updated with NBA
   int              checked_count = 0;
   int              sample_total  = 0;
   int              sample_pass   = 0;
   int              err_count     = 0;
   int              cycle_count   = 0;
   int              hold_left     = 0;
   logic            hold_done     = 1'b0;

   // Applies one message to the gate state and returns the result it must produce.
   function automatic gate_result_type gate_message(range_msg_type m);
      gate_result_type                r;
      logic [scog_pkg::DIST_BITS-1:0] x;
      logic [scog_pkg::DIST_BITS-1:0] old;
      int                             slot;
      logic [63:0]                    n, nx, dev, lhs, nsq, s2, spread_sq;
      r.msg_ok   = 1'b1;
      r.accepted = 1'b0;
      if (m.op == scog_pkg::OP_STATUS) begin
         link_flag = 1'b1;
      end else if (m.op == scog_pkg::OP_SAMPLE) begin
         x = m.distance;
         if (ring_count > WIN) begin
            old        = ring[ring_head];
            win_sum    = win_sum - old;
            win_sumsq  = win_sumsq - old * old;
            ring_head  = (ring_head == RING_DEPTH - 1) ? 0 : ring_head + 1;
            ring_count = ring_count - 1;
         end
         slot = ring_head + ring_count;
         if (slot >= RING_DEPTH) slot = slot - RING_DEPTH;
         ring[slot] = x;
         ring_count = ring_count + 1;
         win_sum    = win_sum + x;
         win_sumsq  = win_sumsq + x * x;
         // |n*x - sum|^2 <= 4*(n*sumsq - sum^2), the new sample included
         n         = ring_count;
         nx        = n * x;
         dev       = (nx >= win_sum) ? nx - win_sum : win_sum - nx;
         lhs       = dev * dev;
         nsq       = n * win_sumsq;
         s2        = win_sum * win_sum;
         spread_sq = (nsq >= s2) ? nsq - s2 : 64'd0;
         if (ring_count < WIN || lhs <= 4 * spread_sq) begin
            held_alt   = x;
            r.accepted = 1'b1;
         end
      end else begin
         link_flag = 1'b0;
         r.msg_ok  = 1'b0;
      end
      r.altitude = held_alt;
      r.link_ok  = link_flag;
      return r;
   endfunction

   // Three phases by progress: sender light / receiver heavy, swapped, then none.
   function automatic int run_phase();
      if (planned_items == 0) return 0;
      return (sent_count * 3) / planned_items;
   endfunction

   function automatic int send_idle_pct();
      case (run_phase())
         0: return 19;
         1: return 86;
         default: return 0;
      endcase
   endfunction

   function automatic int recv_idle_pct();
      case (run_phase())
         0: return 86;
         1: return 19;
         default: return 0;
      endcase
   endfunction

   task automatic report_mismatch(string what, int idx, logic [31:0] want, logic [31:0] got);
      if (err_count < 40)
         $display("mismatch at result %0d: %s expected %0h got %0h", idx, what, want, got);
      err_count++;
   endtask

   task automatic add_msg(logic [1:0] op, logic [scog_pkg::DIST_BITS-1:0] distance);
      range_msg_type m;
      m.op       = op;
      m.distance = distance;
      msg_q.push_back(m);
   endtask

   // Driver: offers the next message once the current transaction is taken.
   always @(posedge clock) begin
      gate_result_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            r = gate_message(offered);
            result_q.push_back(r);
            sent_count <= sent_count + 1;
            if (offered.op == scog_pkg::OP_SAMPLE) begin
               sample_total++;
               if (r.accepted) sample_pass++;
            end
         end
         if (!req_tvalid || req_tready) begin
            if (msg_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
               offered    = msg_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= offered.distance;
               req_tuser  <= offered.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // One long output stall late in the run, while the sender keeps pushing.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && planned_items != 0 && sent_count >= (planned_items * 5) / 6) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else if (hold_left != 0)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct());
   end

   // Monitor: every result transaction against the oldest owed result.
   always @(posedge clock) begin
      gate_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (result_q.size() == 0) begin
            report_mismatch("unexpected result, tdata", checked_count, 32'd0, 32'(rsp_tdata));
         end else begin
            want = result_q.pop_front();
            if (rsp_tuser !== want.msg_ok)
               report_mismatch("message_ok", checked_count, 32'(want.msg_ok), 32'(rsp_tuser));
            if (rsp_tdata[0] !== want.accepted)
               report_mismatch("accepted", checked_count, 32'(want.accepted),
                               32'(rsp_tdata[0]));
            if (rsp_tdata[16:1] !== want.altitude)
               report_mismatch("altitude_cm", checked_count, 32'(want.altitude),
                               32'(rsp_tdata[16:1]));
            if (rsp_tdata[17] !== want.link_ok)
               report_mismatch("link_ok", checked_count, 32'(want.link_ok),
                               32'(rsp_tdata[17]));
         end
         checked_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed", cycle_count, result_q.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned     base;
      int unsigned     spread;
      int              burst;
      int              roll;
      int              v;
      gate_result_type left;

      // Directed: link on/off, reserved op, distance extremes, window filling past the gate.
      add_msg(scog_pkg::OP_STATUS, 16'h0000);
      add_msg(scog_pkg::OP_UNKNOWN, 16'h1234);
      add_msg(OP_RESERVED, 16'hFFFF);
      add_msg(scog_pkg::OP_STATUS, 16'hFFFF);
      add_msg(scog_pkg::OP_SAMPLE, 16'h0000);
      add_msg(scog_pkg::OP_SAMPLE, 16'hFFFF);
      repeat (14) add_msg(scog_pkg::OP_SAMPLE, 16'hFFFF);
      add_msg(scog_pkg::OP_SAMPLE, 16'h0000);   // far outlier against a nearly flat window
      add_msg(scog_pkg::OP_SAMPLE, 16'hFFFF);
      add_msg(scog_pkg::OP_STATUS, 16'h0000);
      add_msg(OP_RESERVED, 16'h0000);

      // Random: bursts of samples clustered around a base, with outliers and control traffic.
      while (msg_q.size() < 24 + RANDOM_ITEMS) begin
         base = $urandom_range(0, 65535);
         if ($urandom_range(0, 9) == 0) base = $urandom_range(0, 1) ? 65535 : 0;
         case ($urandom_range(0, 3))
            0: spread = 0;                           // no spread: clustered samples all equal the base
            1: spread = $urandom_range(1, 40);
            2: spread = $urandom_range(41, 3000);
            default: spread = $urandom_range(3001, 30000);
         endcase
         burst = $urandom_range(12, 48);
         for (int k = 0; k < burst; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 82) begin
               v = int'(base) + int'($urandom_range(0, 2 * spread)) - int'(spread);
               if (v < 0) v = 0;
               if (v > 65535) v = 65535;
               add_msg(scog_pkg::OP_SAMPLE, v[15:0]);
            end else if (roll < 88) begin
               add_msg(scog_pkg::OP_SAMPLE, 16'($urandom_range(0, 65535)));
            end else if (roll < 94) begin
               add_msg(scog_pkg::OP_STATUS, 16'($urandom_range(0, 65535)));
            end else begin
               add_msg($urandom_range(0, 1) ? scog_pkg::OP_UNKNOWN : OP_RESERVED,
                       16'($urandom_range(0, 65535)));
            end
         end
      end
      planned_items = msg_q.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Sample on the falling edge so the checks never race the clocked blocks.
      while (!(sent_count == planned_items && result_q.size() == 0)) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      while (result_q.size() != 0) begin
         left = result_q.pop_front();
         report_mismatch("missing result, altitude_cm", checked_count, 32'(left.altitude), 32'd0);
         checked_count++;
      end

      $display("covered %0d messages: %0d distance samples, %0d passed the gate, %0d rejected",
               sent_count, sample_total, sample_pass, sample_total - sample_pass);
      $display("idling on both sides in turn, one %0d-cycle output stall, %0d results checked",
               HOLD_CYCLES, checked_count);
      if (err_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", err_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- sigma_clip_outlier_gate_unit.f -----
sv/scog_pkg.sv
sv/scog_serial_mult.sv
sv/sigma_clip_outlier_gate_unit.sv
test/sigma_clip_outlier_gate_unit_test.sv
